// ----- sv/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, register indexes and datapath operation codes for the wheel
// speed PI controller.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int PwmMaxDef      = 1000;
  localparam int PwmPeriodDef   = 1000;
  localparam int FilterShiftDef = 2;
  localparam int PeriodMsDef    = 10;
  localparam int InvertDirDef   = 0;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_KP_GAIN        = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI_GAIN        = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_DIVISOR   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_LIMIT = 8'd3;
  localparam logic [CfgIdxW-1:0] CFG_BASE_PWM       = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_PWM_PER_SPEED  = 8'd5;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PWM        = 8'd6;
  localparam logic [CfgIdxW-1:0] CFG_SLEW_STEP      = 8'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_SPD,
    OP_DIV_SPD,
    OP_FILTER,
    OP_MUL_KI,
    OP_INTEG,
    OP_MUL_FF,
    OP_ADD_FF,
    OP_MUL_KP,
    OP_DIV_KP,
    OP_DIV_INT,
    OP_ACC_DIV,
    OP_FINISH,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;
    logic tgt_pos;
  } dp_status_t;

endpackage

// ----- sv/wsp_if.sv -----
// ----------------------------------------------------------------------------
// wsp_in_if / wsp_out_if / wsp_cfg_if
// Valid/ready channels for update requests, results and register writes.
// ----------------------------------------------------------------------------
interface wsp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] target_speed;
  logic signed [15:0] encoder_delta;
  logic        [15:0] elapsed_ms;

  modport source (output valid, command, target_speed, encoder_delta, elapsed_ms,
                  input ready);
  modport sink   (input valid, command, target_speed, encoder_delta, elapsed_ms,
                  output ready);
endinterface

interface wsp_out_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  pwm_level;
  logic        [9:0]  bridge_forward_duty;
  logic        [9:0]  bridge_reverse_duty;
  logic signed [15:0] filtered_speed;

  modport source (output valid, pwm_level, bridge_forward_duty, bridge_reverse_duty,
                  filtered_speed, input ready);
  modport sink   (input valid, pwm_level, bridge_forward_duty, bridge_reverse_duty,
                  filtered_speed, output ready);
endinterface

interface wsp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wsp_pkg::CfgIdxW-1:0]   index;
  logic [wsp_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/wsp_divider.sv -----
// ----------------------------------------------------------------------------
// wsp_divider
// Radix-2 restoring divider, signed 32-bit dividend by unsigned 16-bit
// divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wsp_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dividend_i,
  input  logic        [15:0] divisor_i,
  output logic               done_o,
  output logic signed [32:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [15:0] rem_q;
  logic [15:0] dvs_q;
  logic        neg_q;

  logic [16:0] rem_sh;
  logic [16:0] trial;

  assign rem_sh = {rem_q, dvd_q[31]};
  assign trial  = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        neg_q  <= dividend_i[31];
      end else if (busy_q) begin
        // quotient bits shift in behind the dividend bits
        if (!trial[16]) begin
          rem_q <= trial[15:0];
          dvd_q <= {dvd_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh[15:0];
          dvd_q <= {dvd_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

// ----- sv/wsp_datapath.sv -----
// ----------------------------------------------------------------------------
// wsp_datapath
// Registers, shared multiplier, divider and result registers of the speed
// loop, stepped one operation per cycle by the controller outside divider/output waits.
// ----------------------------------------------------------------------------
module wsp_datapath #(
  parameter int PWM_MAX      = wsp_pkg::PwmMaxDef,
  parameter int PWM_PERIOD   = wsp_pkg::PwmPeriodDef,
  parameter int FILTER_SHIFT = wsp_pkg::FilterShiftDef,
  parameter int PERIOD_MS    = wsp_pkg::PeriodMsDef,
  parameter int INVERT_DIR   = wsp_pkg::InvertDirDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsp_pkg::dp_cmd_t              cmd_i,
  output wsp_pkg::dp_status_t           status_o,
  input  logic                          in_command_i,
  input  logic signed [15:0]            in_target_i,
  input  logic signed [15:0]            in_delta_i,
  input  logic        [15:0]            in_elapsed_i,
  input  logic                          cfg_we_i,
  input  logic [wsp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wsp_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic        [9:0]             pwm_level_o,
  output logic        [9:0]             fwd_duty_o,
  output logic        [9:0]             rev_duty_o,
  output logic signed [15:0]            filt_speed_o
);

  // configuration
  logic        [14:0] kp_q, ki_q;
  logic        [15:0] gdiv_q;
  logic        [30:0] lim_q;
  logic signed [15:0] base_q;
  logic        [9:0]  pps_q, minp_q, slew_q;

  // captured request
  logic               stop_q;
  logic signed [15:0] tgt_q, delta_q;
  logic        [15:0] elap_q;

  // loop state and working registers
  logic signed [31:0] integ_q;
  logic signed [15:0] filt_q;
  logic        [9:0]  pwm_q;
  logic signed [34:0] prod_q;
  logic signed [17:0] err_q;
  logic signed [35:0] acc_q;
  logic signed [15:0] res_filt_q;

  // results
  logic        [9:0]  pwm_out_q, fwd_q, rev_q;
  logic signed [15:0] filt_out_q;

  // multiplier operands
  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;

  always_comb begin
    unique case (cmd_i.op)
      wsp_pkg::OP_MUL_SPD: begin
        mul_a = 18'(delta_q);
        mul_b = 17'(PERIOD_MS);
      end
      wsp_pkg::OP_MUL_KI: begin
        mul_a = err_q;
        mul_b = $signed({2'b00, ki_q});
      end
      wsp_pkg::OP_MUL_KP: begin
        mul_a = err_q;
        mul_b = $signed({2'b00, kp_q});
      end
      default: begin
        mul_a = 18'(tgt_q);
        mul_b = $signed({7'b0, pps_q});
      end
    endcase
  end

  // divider
  logic               div_start;
  logic signed [31:0] div_dvd;
  logic        [15:0] div_dvs;
  logic               div_done;
  logic signed [32:0] div_quo;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = integ_q;
    div_dvs   = (gdiv_q == 16'd0) ? 16'd1 : gdiv_q;
    unique case (cmd_i.op)
      wsp_pkg::OP_DIV_SPD: begin
        div_start = 1'b1;
        div_dvd   = prod_q[31:0];
        div_dvs   = (elap_q == 16'd0) ? 16'd1 : elap_q;
      end
      wsp_pkg::OP_DIV_KP: begin
        div_start = 1'b1;
        div_dvd   = prod_q[31:0];
      end
      wsp_pkg::OP_DIV_INT: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  wsp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // filter step
  localparam logic signed [17:0] FiltBias = 18'((1 << FILTER_SHIFT) - 1);

  logic signed [15:0] raw;
  logic signed [17:0] diff;
  logic signed [17:0] fstep;
  logic signed [15:0] filt_new;

  always_comb begin
    if (div_quo > 33'sd32767) begin
      raw = 16'sh7fff;
    end else if (div_quo < -33'sd32768) begin
      raw = -16'sh8000;
    end else begin
      raw = div_quo[15:0];
    end
    diff  = 18'(raw) - 18'(filt_q);
    // arithmetic shift rounds down; bias negatives to truncate toward zero
    fstep = diff[17] ? ((diff + FiltBias) >>> FILTER_SHIFT) : (diff >>> FILTER_SHIFT);
    filt_new = 16'(18'(filt_q) + fstep);
  end

  // integral clamp
  logic signed [35:0] iacc;
  logic signed [35:0] ilim;

  assign iacc = 36'(integ_q) + 36'(prod_q);
  assign ilim = $signed({5'b0, lim_q});

  // output clamp, minimum and slew
  logic        [9:0]  out_c, out_m, out_s, minp, duty;
  logic        [10:0] hi;
  logic signed [11:0] lo;

  always_comb begin
    if (acc_q < 36'sd0) begin
      out_c = '0;
    end else if (acc_q > 36'(PWM_MAX)) begin
      out_c = 10'(PWM_MAX);
    end else begin
      out_c = acc_q[9:0];
    end
    minp  = ({22'b0, minp_q} > 32'(PWM_MAX)) ? 10'(PWM_MAX) : minp_q;
    out_m = (out_c != 10'd0 && out_c < minp) ? minp : out_c;
    hi    = {1'b0, pwm_q} + {1'b0, slew_q};
    lo    = $signed({2'b00, pwm_q}) - $signed({2'b00, slew_q});
    if ({1'b0, out_m} > hi) begin
      out_s = hi[9:0];
    end else if ($signed({2'b00, out_m}) < lo) begin
      out_s = lo[9:0];
    end else begin
      out_s = out_m;
    end
    duty = ({22'b0, pwm_q} > 32'(PWM_PERIOD)) ? 10'(PWM_PERIOD) : pwm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      gdiv_q     <= 16'd1;
      lim_q      <= '0;
      base_q     <= '0;
      pps_q      <= '0;
      minp_q     <= '0;
      slew_q     <= 10'd1;
      stop_q     <= 1'b0;
      tgt_q      <= '0;
      delta_q    <= '0;
      elap_q     <= '0;
      integ_q    <= '0;
      filt_q     <= '0;
      pwm_q      <= '0;
      prod_q     <= '0;
      err_q      <= '0;
      acc_q      <= '0;
      res_filt_q <= '0;
      pwm_out_q  <= '0;
      fwd_q      <= '0;
      rev_q      <= '0;
      filt_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          wsp_pkg::CFG_KP_GAIN:        kp_q   <= cfg_data_i[14:0];
          wsp_pkg::CFG_KI_GAIN:        ki_q   <= cfg_data_i[14:0];
          wsp_pkg::CFG_GAIN_DIVISOR:   gdiv_q <= cfg_data_i[15:0];
          wsp_pkg::CFG_INTEGRAL_LIMIT: lim_q  <= cfg_data_i[30:0];
          wsp_pkg::CFG_BASE_PWM:       base_q <= cfg_data_i[15:0];
          wsp_pkg::CFG_PWM_PER_SPEED:  pps_q  <= cfg_data_i[9:0];
          wsp_pkg::CFG_MIN_PWM:        minp_q <= cfg_data_i[9:0];
          wsp_pkg::CFG_SLEW_STEP:      slew_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        wsp_pkg::OP_LOAD: begin
          stop_q  <= in_command_i;
          tgt_q   <= in_target_i;
          delta_q <= in_delta_i;
          elap_q  <= in_elapsed_i;
          acc_q   <= 36'(base_q);
          if (in_command_i) begin
            integ_q    <= '0;
            filt_q     <= '0;
            pwm_q      <= '0;
            res_filt_q <= '0;
          end
        end
        wsp_pkg::OP_MUL_SPD,
        wsp_pkg::OP_MUL_KI,
        wsp_pkg::OP_MUL_FF,
        wsp_pkg::OP_MUL_KP: begin
          prod_q <= 35'(mul_a * mul_b);
        end
        wsp_pkg::OP_FILTER: begin
          res_filt_q <= filt_new;
          err_q      <= 18'(tgt_q) - 18'(filt_new);
          if (tgt_q > 16'sd0) begin
            filt_q <= filt_new;
          end else begin
            integ_q <= '0;
            filt_q  <= '0;
            pwm_q   <= '0;
          end
        end
        wsp_pkg::OP_INTEG: begin
          if (iacc > ilim) begin
            integ_q <= ilim[31:0];
          end else if (iacc < -ilim) begin
            integ_q <= 32'(-ilim);
          end else begin
            integ_q <= iacc[31:0];
          end
        end
        wsp_pkg::OP_ADD_FF:  acc_q <= acc_q + 36'(prod_q);
        wsp_pkg::OP_ACC_DIV: acc_q <= acc_q + 36'(div_quo);
        wsp_pkg::OP_FINISH:  pwm_q <= out_s;
        wsp_pkg::OP_PUBLISH: begin
          pwm_out_q  <= pwm_q;
          fwd_q      <= (INVERT_DIR == 0) ? duty : 10'd0;
          rev_q      <= (INVERT_DIR == 0) ? 10'd0 : duty;
          filt_out_q <= res_filt_q;
        end
        default: ;
      endcase
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.stop     = stop_q;
  assign status_o.tgt_pos  = (tgt_q > 16'sd0);

  assign pwm_level_o  = pwm_out_q;
  assign fwd_duty_o   = fwd_q;
  assign rev_duty_o   = rev_q;
  assign filt_speed_o = filt_out_q;

endmodule

// ----- sv/wsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wsp_ctrl
// Sequencer: walks the datapath through one update and owns the handshakes.
// ----------------------------------------------------------------------------
module wsp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  wsp_pkg::dp_status_t status_i,
  output wsp_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_SPD, S_DIV_SPD, S_WAIT_SPD, S_FILT, S_MUL_KI, S_INTEG,
    S_MUL_FF, S_ADD_FF, S_MUL_KP, S_DIV_KP, S_WAIT_KP, S_ACC_KP,
    S_DIV_INT, S_WAIT_INT, S_ACC_INT, S_FINISH, S_PUBLISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.op = wsp_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = wsp_pkg::OP_LOAD;
      S_MUL_SPD:  if (!status_i.stop) cmd_o.op = wsp_pkg::OP_MUL_SPD;
      S_DIV_SPD:  cmd_o.op = wsp_pkg::OP_DIV_SPD;
      S_FILT:     cmd_o.op = wsp_pkg::OP_FILTER;
      S_MUL_KI:   cmd_o.op = wsp_pkg::OP_MUL_KI;
      S_INTEG:    cmd_o.op = wsp_pkg::OP_INTEG;
      S_MUL_FF:   cmd_o.op = wsp_pkg::OP_MUL_FF;
      S_ADD_FF:   cmd_o.op = wsp_pkg::OP_ADD_FF;
      S_MUL_KP:   cmd_o.op = wsp_pkg::OP_MUL_KP;
      S_DIV_KP:   cmd_o.op = wsp_pkg::OP_DIV_KP;
      S_ACC_KP:   cmd_o.op = wsp_pkg::OP_ACC_DIV;
      S_DIV_INT:  cmd_o.op = wsp_pkg::OP_DIV_INT;
      S_ACC_INT:  cmd_o.op = wsp_pkg::OP_ACC_DIV;
      S_FINISH:   cmd_o.op = wsp_pkg::OP_FINISH;
      S_PUBLISH:  if (slot_free) cmd_o.op = wsp_pkg::OP_PUBLISH;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_PUBLISH && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_MUL_SPD;
        S_MUL_SPD:  state_q <= status_i.stop ? S_PUBLISH : S_DIV_SPD;
        S_DIV_SPD:  state_q <= S_WAIT_SPD;
        S_WAIT_SPD: if (status_i.div_done) state_q <= S_FILT;
        S_FILT:     state_q <= status_i.tgt_pos ? S_MUL_KI : S_PUBLISH;
        S_MUL_KI:   state_q <= S_INTEG;
        S_INTEG:    state_q <= S_MUL_FF;
        S_MUL_FF:   state_q <= S_ADD_FF;
        S_ADD_FF:   state_q <= S_MUL_KP;
        S_MUL_KP:   state_q <= S_DIV_KP;
        S_DIV_KP:   state_q <= S_WAIT_KP;
        S_WAIT_KP:  if (status_i.div_done) state_q <= S_ACC_KP;
        S_ACC_KP:   state_q <= S_DIV_INT;
        S_DIV_INT:  state_q <= S_WAIT_INT;
        S_WAIT_INT: if (status_i.div_done) state_q <= S_ACC_INT;
        S_ACC_INT:  state_q <= S_FINISH;
        S_FINISH:   state_q <= S_PUBLISH;
        S_PUBLISH:  if (slot_free) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/wheel_speed_pi_controller_core.sv -----
// ----------------------------------------------------------------------------
// wheel_speed_pi_controller_core
// Per-wheel PI speed loop with feedforward, minimum duty and slew limit.
// ----------------------------------------------------------------------------
// One request at a time. The next request can be accepted in the cycle after
// the result is published. The speed, proportional and integral terms share
// one radix-2 divider, and all products share one multiplier. A finished
// result waits in the output register while the next request is accepted.
// Register writes are always ready.
module wheel_speed_pi_controller_core #(
  parameter int PWM_MAX      = wsp_pkg::PwmMaxDef,
  parameter int PWM_PERIOD   = wsp_pkg::PwmPeriodDef,
  parameter int FILTER_SHIFT = wsp_pkg::FilterShiftDef,
  parameter int PERIOD_MS    = wsp_pkg::PeriodMsDef,
  parameter int INVERT_DIR   = wsp_pkg::InvertDirDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsp_in_if.sink     in_ch_i,
  wsp_out_if.source  out_ch_o,
  wsp_cfg_if.sink    cfg_i
);

  wsp_pkg::dp_cmd_t    cmd;
  wsp_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  wsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wsp_datapath #(
    .PWM_MAX      (PWM_MAX),
    .PWM_PERIOD   (PWM_PERIOD),
    .FILTER_SHIFT (FILTER_SHIFT),
    .PERIOD_MS    (PERIOD_MS),
    .INVERT_DIR   (INVERT_DIR)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_command_i (in_ch_i.command),
    .in_target_i  (in_ch_i.target_speed),
    .in_delta_i   (in_ch_i.encoder_delta),
    .in_elapsed_i (in_ch_i.elapsed_ms),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .pwm_level_o  (out_ch_o.pwm_level),
    .fwd_duty_o   (out_ch_o.bridge_forward_duty),
    .rev_duty_o   (out_ch_o.bridge_reverse_duty),
    .filt_speed_o (out_ch_o.filtered_speed)
  );

`ifndef SYNTH
  a_one_leg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> (out_ch_o.bridge_forward_duty == 10'd0 ||
                        out_ch_o.bridge_reverse_duty == 10'd0))
    else $error("both bridge legs driven");

  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> ({22'b0, out_ch_o.pwm_level} <= 32'(PWM_MAX)))
    else $error("pwm level above maximum");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |=> !in_ch_i.ready)
    else $error("request accepted while busy");

  a_publish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == wsp_pkg::OP_PUBLISH) |-> (!out_ch_o.valid || out_ch_o.ready))
    else $error("result overwritten before taken");
`endif

endmodule

// ----- test/wheel_speed_pi_controller_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_pi_controller_core_checker
// Tracks register writes and accepted update requests, computes the expected
// duty and filtered speed for each one, and checks every accepted result.
// ----------------------------------------------------------------------------
module wheel_speed_pi_controller_core_checker #(
  parameter int PWM_MAX      = wsp_pkg::PwmMaxDef,
  parameter int PWM_PERIOD   = wsp_pkg::PwmPeriodDef,
  parameter int FILTER_SHIFT = wsp_pkg::FilterShiftDef,
  parameter int PERIOD_MS    = wsp_pkg::PeriodMsDef,
  parameter int INVERT_DIR   = wsp_pkg::InvertDirDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wsp_in_if.sink   req_mon,
  wsp_out_if.sink  res_mon,
  wsp_cfg_if.sink  cfg_mon,
  output int       fail_count_o,
  output int       pending_o,
  output int       result_count_o
);

  typedef struct packed {
    logic [9:0]         pwm;
    logic [9:0]         fwd;
    logic [9:0]         rev;
    logic signed [15:0] speed;
  } duty_t;

  duty_t duty_q[$];

  logic [14:0]        kp, ki;
  logic [15:0]        gdiv;
  logic [30:0]        ilimit;
  logic signed [15:0] base;
  logic [9:0]         ff_gain, min_duty, slew;
  logic signed [31:0] integ;
  logic signed [31:0] filt;
  int                 duty_now;
  int                 fails;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  task automatic predict_duty(input logic cmd, input logic signed [15:0] tgt,
                              input logic signed [15:0] dlt, input logic [15:0] ms);
    duty_t  r;
    longint raw, err, acc, lim, dv, outv, mp, d;
    r = '0;
    if (cmd) begin
      integ = 0; filt = 0; duty_now = 0;
    end else begin
      dv  = (ms == 0) ? 1 : longint'(ms);
      raw = clamp(longint'(dlt) * PERIOD_MS / dv, -32768, 32767);
      filt = filt + (32'(raw) - filt) / (32'sd1 <<< FILTER_SHIFT);
      r.speed = filt[15:0];
      if (tgt <= 0) begin
        integ = 0; filt = 0; duty_now = 0;
      end else begin
        err = longint'(tgt) - longint'(filt);
        lim = longint'(ilimit);
        integ = 32'(clamp(longint'(integ) + longint'(ki) * err, -lim, lim));
        dv = (gdiv == 0) ? 1 : longint'(gdiv);
        acc = longint'(base) + longint'(tgt) * longint'(ff_gain)
            + (longint'(kp) * err) / dv + longint'(integ) / dv;
        outv = clamp(acc, 0, PWM_MAX);
        mp = (min_duty > PWM_MAX) ? PWM_MAX : longint'(min_duty);
        if (outv > 0 && outv < mp) outv = mp;
        if (outv > duty_now + slew) outv = duty_now + slew;
        else if (outv < duty_now - longint'(slew)) outv = duty_now - slew;
        duty_now = int'(outv);
        d = (duty_now > PWM_PERIOD) ? PWM_PERIOD : duty_now;
        r.pwm = 10'(duty_now);
        if (INVERT_DIR == 0) r.fwd = 10'(d);
        else r.rev = 10'(d);
      end
    end
    duty_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_t e;
    if (!rst_ni) begin
      kp = 0; ki = 0; gdiv = 1; ilimit = 0; base = 0;
      ff_gain = 0; min_duty = 0; slew = 1;
      integ = 0; filt = 0; duty_now = 0;
      fails = 0; result_count_o = 0;
      duty_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          wsp_pkg::CFG_KP_GAIN:        kp = cfg_mon.data[14:0];
          wsp_pkg::CFG_KI_GAIN:        ki = cfg_mon.data[14:0];
          wsp_pkg::CFG_GAIN_DIVISOR:   gdiv = cfg_mon.data[15:0];
          wsp_pkg::CFG_INTEGRAL_LIMIT: ilimit = cfg_mon.data[30:0];
          wsp_pkg::CFG_BASE_PWM:       base = cfg_mon.data[15:0];
          wsp_pkg::CFG_PWM_PER_SPEED:  ff_gain = cfg_mon.data[9:0];
          wsp_pkg::CFG_MIN_PWM:        min_duty = cfg_mon.data[9:0];
          wsp_pkg::CFG_SLEW_STEP:      slew = cfg_mon.data[9:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        result_count_o++;
        if (duty_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result with no request pending");
        end else begin
          e = duty_q.pop_front();
          if (e.pwm !== res_mon.pwm_level || e.fwd !== res_mon.bridge_forward_duty ||
              e.rev !== res_mon.bridge_reverse_duty ||
              e.speed !== res_mon.filtered_speed) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp pwm %0d fwd %0d rev %0d spd %0d, got %0d %0d %0d %0d",
                       e.pwm, e.fwd, e.rev, e.speed, res_mon.pwm_level,
                       res_mon.bridge_forward_duty, res_mon.bridge_reverse_duty,
                       res_mon.filtered_speed);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        predict_duty(req_mon.command, req_mon.target_speed, req_mon.encoder_delta,
                     req_mon.elapsed_ms);
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = duty_q.size();
endmodule

// ----- test/wheel_speed_pi_controller_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_pi_controller_core_tb
// Drives update requests and register writes through several gain settings
// with random gaps and back-pressure; the checker compares every result.
// ----------------------------------------------------------------------------
module wheel_speed_pi_controller_core_tb;

  localparam longint CycleLimit = 1_500_000;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending, result_count;
  longint cycles;
  int   idle_pct;
  bit   hold_res;
  int   hold_cycles;
  int   sent;

  wsp_in_if  in_ch();
  wsp_out_if out_ch();
  wsp_cfg_if cfg_ch();

  wheel_speed_pi_controller_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch_i(in_ch), .out_ch_o(out_ch), .cfg_i(cfg_ch)
  );

  wheel_speed_pi_controller_core_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_mon(in_ch), .res_mon(out_ch),
    .cfg_mon(cfg_ch), .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("wheel_speed_pi_controller_core_tb: errors");
        $finish;
      end
    end
  end

  // result side: random stalls, or a long hold-off when requested
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_res && hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // valid stays up after the accepting edge; an idle gap in the next call, or drain, drops it
  task automatic send_req(input logic cmd, input logic [15:0] tgt,
                          input logic [15:0] dlt, input logic [15:0] ms);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.target_speed  <= tgt;
    in_ch.encoder_delta <= dlt;
    in_ch.elapsed_ms    <= ms;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic write_reg(input logic [wsp_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic drain;
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    while (n < 150) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic set_gains(input int kp, input int ki, input int gd, input int lim,
                           input int bp, input int ff, input int mn, input int sl);
    drain();
    write_reg(wsp_pkg::CFG_KP_GAIN, kp);
    write_reg(wsp_pkg::CFG_KI_GAIN, ki);
    write_reg(wsp_pkg::CFG_GAIN_DIVISOR, gd);
    write_reg(wsp_pkg::CFG_INTEGRAL_LIMIT, lim);
    write_reg(wsp_pkg::CFG_BASE_PWM, bp);
    write_reg(wsp_pkg::CFG_PWM_PER_SPEED, ff);
    write_reg(wsp_pkg::CFG_MIN_PWM, mn);
    write_reg(wsp_pkg::CFG_SLEW_STEP, sl);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_run(input int count);
    logic [15:0] tgt, dlt, ms;
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0:       tgt = 16'($urandom);
        1:       tgt = 16'(-$urandom_range(200));
        default: tgt = 16'($urandom_range(300));
      endcase
      dlt = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(400) - 100);
      ms  = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(20));
      send_req($urandom_range(29) == 0, tgt, dlt, ms);
    end
  endtask

  initial begin
    rst_ni = 0;
    sent = 0;
    idle_pct = 31;
    hold_res = 0;
    hold_cycles = 0;
    in_ch.valid = 0; in_ch.command = 0; in_ch.target_speed = 0;
    in_ch.encoder_delta = 0; in_ch.elapsed_ms = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains, then edge settings
    send_req(1'b0, 16'sd100, 16'sd40, 16'd10);
    set_gains(32767, 32767, 1, 32'h7fff_ffff, 32767, 1023, 1023, 1000);
    send_req(1'b0, 16'sh7fff, 16'sh7fff, 16'd1);
    send_req(1'b0, 16'sh7fff, 16'sh8000, 16'd0);
    send_req(1'b0, 16'sd1, 16'sh8000, 16'hffff);
    send_req(1'b0, 16'sh8000, 16'sd0, 16'd5);
    send_req(1'b0, 16'sd0, 16'sd100, 16'd10);
    send_req(1'b1, 16'shffff, 16'shffff, 16'hffff);
    send_req(1'b0, 16'sd50, 16'sd20, 16'd10);
    set_gains(100, 50, 0, 0, -32768, 0, 500, 0);
    send_req(1'b0, 16'sd200, 16'sd10, 16'd10);
    send_req(1'b0, 16'sd200, 16'sd10, 16'd10);
    set_gains(200, 300, 65535, 1000, 10, 2, 0, 5);
    send_req(1'b0, 16'sd100, 16'sd0, 16'd10);
    send_req(1'b0, 16'sd100, -16'sd50, 16'd3);
    send_req(1'b1, 16'sd100, 16'sd0, 16'd10);
    drain();
    write_reg(8'd200, 32'hffff_ffff);
    cfg_ch.valid <= 1'b0;

    // typical tuning; one long hold-off on the result side
    set_gains(400, 20, 16, 20000, 50, 3, 80, 40);
    hold_res = 1; hold_cycles = 600;
    random_run(10);
    hold_res = 0;
    drain();
    idle_pct = 0;
    random_run(150);
    idle_pct = 31;
    random_run(200);
    set_gains($urandom_range(32767), $urandom_range(32767), $urandom_range(65535, 1),
              $urandom, $urandom_range(65535), $urandom_range(1023),
              $urandom_range(1000), $urandom_range(1000, 1));
    random_run(250);
    set_gains(1500, 100, 100, 2000000, -200, 5, 1000, 1000);
    random_run(300);
    drain();

    $display("covered %0d requests, %0d results, six gain settings", sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("wheel_speed_pi_controller_core_tb: clean");
    end else begin
      $display("wheel_speed_pi_controller_core_tb: errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/wsp_pkg.sv
sv/wsp_if.sv
sv/wsp_divider.sv
sv/wsp_datapath.sv
sv/wsp_ctrl.sv
sv/wheel_speed_pi_controller_core.sv
test/wheel_speed_pi_controller_core_checker.sv
test/wheel_speed_pi_controller_core_tb.sv
